### design/free_block_stack_with_spill_core_macros.svh
// assertion macros shared by the free block stack design
`ifndef FREE_BLOCK_STACK_WITH_SPILL_CORE_MACROS_SVH
`define FREE_BLOCK_STACK_WITH_SPILL_CORE_MACROS_SVH

// antecedent and consequent in the same cycle
`define FBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define FBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fbs_pkg.sv
// shared types and codes for the free block stack
`timescale 1ns / 1ps

package fbs_pkg;

    localparam int ID_W       = 31;
    localparam int TOTAL_W    = 11;
    localparam int MOVED_W    = 2;
    localparam int MBLK_W     = 6;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 4;

    typedef logic [2:0] t_op;

    localparam t_op OP_PUSH   = 3'd0;
    localparam t_op OP_POP    = 3'd1;
    localparam t_op OP_SPILL  = 3'd2;
    localparam t_op OP_REFILL = 3'd3;
    localparam t_op OP_FULL   = 3'd4;
    localparam t_op OP_EMPTY  = 3'd5;

    typedef logic [MOVED_W-1:0] t_moved;

    localparam t_moved MOVED_NONE   = 2'd0;
    localparam t_moved MOVED_SPILL  = 2'd1;
    localparam t_moved MOVED_REFILL = 2'd2;

    localparam logic ACT_FREE  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

endpackage

### design/free_block_stack_with_spill_core.sv
// Free block id stack with a small top store that spills to and refills from
// a backing store of ENTRIES_PER_BLOCK-id blocks. The front end takes one
// request per cycle while its two-entry command queue has room; the back end
// carries out one command at a time. A plain free, a plain allocate and a
// rejected or empty request go from the idle state to the finish state; a
// spill or a refill passes through the spill or refill state on the way,
// since each store has one read port and a block moves one id per cycle.
// Results sit in an output register, so a stalled consumer holds only the back
// end while the front keeps filling the queue. Neither store is cleared after
// reset: no entry is read before it is written.
`timescale 1ns / 1ps
`include "free_block_stack_with_spill_core_macros.svh"

module free_block_stack_with_spill_core #(
    parameter int ENTRIES_PER_BLOCK = 16,
    parameter int BACKING_BLOCKS    = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // block_id[30:0], zero pad [31]
    input  logic [fbs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action[0]
    input  logic [fbs_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // got_id[30:0], total_free[41:31], moved_block[47:42]
    output logic [fbs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // empty_res[0], full_res[1], moved[3:2]
    output logic [fbs_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import fbs_pkg::*;

    localparam int TOP_DEPTH = 2 * ENTRIES_PER_BLOCK - 1;
    localparam int TAW       = $clog2(TOP_DEPTH);
    localparam int BW        = (BACKING_BLOCKS > 1) ? $clog2(BACKING_BLOCKS) : 1;
    localparam int TW        = $clog2(TOP_DEPTH + BACKING_BLOCKS * ENTRIES_PER_BLOCK);

    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] id;
        logic [TAW-1:0]  addr;
        logic [BW-1:0]   blk;
        logic [TW-1:0]   total;
    } t_cmd;

    logic fe_valid, fe_ready;
    t_cmd fe_cmd;
    logic q_valid, q_ready;
    t_cmd q_cmd;

    fbs_front #(
        .ENTRIES_PER_BLOCK (ENTRIES_PER_BLOCK),
        .BACKING_BLOCKS    (BACKING_BLOCKS),
        .t_cmd             (t_cmd)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tuser[0]),
        .i_block_id  (s_axis_tdata[ID_W-1:0]),
        .o_cmd_valid (fe_valid),
        .i_cmd_ready (fe_ready),
        .o_cmd       (fe_cmd)
    );

    fbs_queue #(
        .t_cmd (t_cmd)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_valid),
        .o_wr_ready (fe_ready),
        .i_wr_data  (fe_cmd),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_cmd)
    );

    fbs_back #(
        .ENTRIES_PER_BLOCK (ENTRIES_PER_BLOCK),
        .BACKING_BLOCKS    (BACKING_BLOCKS),
        .t_cmd             (t_cmd)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser)
    );

    // an accepted request is in the queue on the next cycle
    `FBS_ASSERT_NEXT(a_req_queued, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, q_valid, "accepted request missing from queue")
    // empty and full never flag the same result
    `FBS_ASSERT_SAME(a_flags_excl, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "empty and full both set")
    // a rejected or empty request moves no block
    `FBS_ASSERT_SAME(a_flag_no_move, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]), m_axis_tuser[3:2] == MOVED_NONE, "flagged result reports a block move")

endmodule

### design/fbs_front.sv
// front end: tracks the counts and turns each request into a command
`timescale 1ns / 1ps

module fbs_front #(
    parameter int  ENTRIES_PER_BLOCK = 16,
    parameter int  BACKING_BLOCKS    = 64,
    parameter type t_cmd             = logic
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_action,
    input  logic [fbs_pkg::ID_W-1:0]     i_block_id,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output t_cmd                         o_cmd
);
    import fbs_pkg::*;

    localparam int TOP_DEPTH = 2 * ENTRIES_PER_BLOCK - 1;
    localparam int TAW       = $clog2(TOP_DEPTH);
    localparam int BW        = (BACKING_BLOCKS > 1) ? $clog2(BACKING_BLOCKS) : 1;
    localparam int SW        = $clog2(BACKING_BLOCKS + 1);
    localparam int TW        = $clog2(TOP_DEPTH + BACKING_BLOCKS * ENTRIES_PER_BLOCK);

    logic [TAW-1:0] r_top,   n_top;
    logic [SW-1:0]  r_spill, n_spill;
    logic [TW-1:0]  r_total, n_total;
    logic           accept;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign accept      = i_valid && i_cmd_ready;

    always_comb begin
        n_top       = r_top;
        n_spill     = r_spill;
        n_total     = r_total;
        o_cmd.op    = OP_EMPTY;
        o_cmd.id    = i_block_id;
        o_cmd.addr  = r_top;
        o_cmd.blk   = '0;
        if (i_action == ACT_FREE) begin
            if (r_top < TAW'(TOP_DEPTH - 1)) begin
                o_cmd.op = OP_PUSH;
                n_top    = r_top + TAW'(1);
                n_total  = r_total + TW'(1);
            end else if (r_spill == SW'(BACKING_BLOCKS)) begin
                o_cmd.op = OP_FULL;
            end else begin
                // last id goes straight to the backing block, rest follow top first
                o_cmd.op  = OP_SPILL;
                o_cmd.blk = BW'(r_spill);
                n_top     = TAW'(ENTRIES_PER_BLOCK - 1);
                n_spill   = r_spill + SW'(1);
                n_total   = r_total + TW'(1);
            end
        end else begin
            if (r_total == '0) begin
                o_cmd.op = OP_EMPTY;
            end else if (r_top == '0) begin
                if (r_spill == '0) begin
                    o_cmd.op = OP_EMPTY;
                end else begin
                    o_cmd.op  = OP_REFILL;
                    o_cmd.blk = BW'(r_spill - SW'(1));
                    n_top     = TAW'(ENTRIES_PER_BLOCK - 1);
                    n_spill   = r_spill - SW'(1);
                    n_total   = r_total - TW'(1);
                end
            end else begin
                o_cmd.op   = OP_POP;
                o_cmd.addr = r_top - TAW'(1);
                n_top      = r_top - TAW'(1);
                n_total    = r_total - TW'(1);
            end
        end
        o_cmd.total = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_spill <= '0;
            r_total <= '0;
        end else if (accept) begin
            r_top   <= n_top;
            r_spill <= n_spill;
            r_total <= n_total;
        end
    end

endmodule

### design/fbs_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps

module fbs_queue #(
    parameter type t_cmd = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_cmd i_wr_data,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_cmd o_rd_data
);
    import fbs_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       wr_en;
    logic       rd_en;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_slot[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### design/fbs_back.sv
// back end: top and backing stores, spill and refill sequencer, result register
`timescale 1ns / 1ps

module fbs_back #(
    parameter int  ENTRIES_PER_BLOCK = 16,
    parameter int  BACKING_BLOCKS    = 64,
    parameter type t_cmd             = logic
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    output logic                               o_cmd_ready,
    input  t_cmd                               i_cmd,
    output logic                               o_tvalid,
    input  logic                               i_tready,
    output logic [fbs_pkg::OUT_DATA_W-1:0]     o_tdata,
    output logic [fbs_pkg::OUT_USER_W-1:0]     o_tuser
);
    import fbs_pkg::*;

    localparam int TOP_DEPTH  = 2 * ENTRIES_PER_BLOCK - 1;
    localparam int TAW        = $clog2(TOP_DEPTH);
    localparam int BACK_DEPTH = BACKING_BLOCKS * ENTRIES_PER_BLOCK;
    localparam int BAW        = $clog2(BACK_DEPTH);
    localparam int KW         = $clog2(ENTRIES_PER_BLOCK);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SPILL  = 2'd1;
    localparam logic [1:0] ST_REFILL = 2'd2;
    localparam logic [1:0] ST_FIN    = 2'd3;

    logic [ID_W-1:0] r_top_mem [TOP_DEPTH];
    logic [ID_W-1:0] r_bk_mem  [BACK_DEPTH];
    logic [ID_W-1:0] r_top_rd;
    logic [ID_W-1:0] r_bk_rd;

    logic [1:0]      r_state, n_state;
    t_cmd            r_cmd,   n_cmd;
    logic [KW-1:0]   r_k,     n_k;
    logic [BAW-1:0]  r_base,  n_base;
    logic            r_out_valid;
    logic [OUT_DATA_W-1:0] r_tdata;
    logic [OUT_USER_W-1:0] r_tuser;

    logic            top_we, top_re, bk_we, bk_re;
    logic [TAW-1:0]  top_wa, top_ra;
    logic [BAW-1:0]  bk_wa, bk_ra;
    logic [ID_W-1:0] top_wd, bk_wd;
    logic            out_load;
    logic [ID_W-1:0] got;
    t_moved          moved;
    logic [MBLK_W-1:0] mblk;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_tvalid    = r_out_valid;
    assign o_tdata     = r_tdata;
    assign o_tuser     = r_tuser;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_k      = r_k;
        n_base   = r_base;
        top_we   = 1'b0;
        top_wa   = '0;
        top_wd   = '0;
        top_re   = 1'b0;
        top_ra   = '0;
        bk_we    = 1'b0;
        bk_wa    = '0;
        bk_wd    = '0;
        bk_re    = 1'b0;
        bk_ra    = '0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd  = i_cmd;
                    n_base = BAW'(int'(i_cmd.blk) * ENTRIES_PER_BLOCK);
                    n_state = ST_FIN;
                    unique case (i_cmd.op)
                        OP_PUSH: begin
                            top_we = 1'b1;
                            top_wa = i_cmd.addr;
                            top_wd = i_cmd.id;
                        end
                        OP_POP: begin
                            top_re = 1'b1;
                            top_ra = i_cmd.addr;
                        end
                        OP_SPILL: begin
                            bk_we   = 1'b1;
                            bk_wa   = n_base;
                            bk_wd   = i_cmd.id;
                            top_re  = 1'b1;
                            top_ra  = TAW'(TOP_DEPTH - 2);
                            n_k     = KW'(1);
                            n_state = ST_SPILL;
                        end
                        OP_REFILL: begin
                            bk_re   = 1'b1;
                            bk_ra   = n_base;
                            n_k     = '0;
                            n_state = ST_REFILL;
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_SPILL: begin
                bk_we = 1'b1;
                bk_wa = r_base + BAW'(r_k);
                bk_wd = r_top_rd;
                if (r_k == KW'(ENTRIES_PER_BLOCK - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    // entry k+1 of the block comes from top index 2M-3-k
                    top_re = 1'b1;
                    top_ra = TAW'(TOP_DEPTH - 2) - TAW'(r_k);
                    n_k    = r_k + KW'(1);
                end
            end
            ST_REFILL: begin
                top_we = 1'b1;
                top_wa = TAW'(r_k);
                top_wd = r_bk_rd;
                if (r_k == KW'(ENTRIES_PER_BLOCK - 1)) begin
                    // last entry read is the popped id, held in r_bk_rd
                    n_state = ST_FIN;
                end else begin
                    bk_re = 1'b1;
                    bk_ra = r_base + BAW'(r_k) + BAW'(1);
                    n_k   = r_k + KW'(1);
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        got   = '0;
        moved = MOVED_NONE;
        mblk  = '0;
        case (r_cmd.op)
            OP_POP: begin
                got = r_top_rd;
            end
            OP_REFILL: begin
                got   = r_bk_rd;
                moved = MOVED_REFILL;
                mblk  = MBLK_W'(r_cmd.blk);
            end
            OP_SPILL: begin
                moved = MOVED_SPILL;
                mblk  = MBLK_W'(r_cmd.blk);
            end
            default: begin
                got = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_k    <= n_k;
        r_base <= n_base;
        if (out_load) begin
            r_tdata <= {mblk, TOTAL_W'(r_cmd.total), got};
            r_tuser <= {moved, (r_cmd.op == OP_FULL), (r_cmd.op == OP_EMPTY)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (top_we) begin
            r_top_mem[top_wa] <= top_wd;
        end
        if (top_re) begin
            r_top_rd <= r_top_mem[top_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bk_we) begin
            r_bk_mem[bk_wa] <= bk_wd;
        end
        if (bk_re) begin
            r_bk_rd <= r_bk_mem[bk_ra];
        end
    end

endmodule

### dv/free_block_stack_checker.sv
// checker for the free block stack: predicts every answer and compares the result stream
`timescale 1ns / 1ps

module free_block_stack_checker #(
    parameter int ENTRIES_PER_BLOCK = 16,
    parameter int BACKING_BLOCKS    = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    input  logic                               i_s_axis_tready,
    // block_id[30:0], zero pad [31]
    input  logic [fbs_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // action[0]
    input  logic [fbs_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    input  logic                               i_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // got_id[30:0], total_free[41:31], moved_block[47:42]
    input  logic [fbs_pkg::OUT_DATA_W-1:0]     i_m_axis_tdata,
    // empty_res[0], full_res[1], moved[3:2]
    input  logic [fbs_pkg::OUT_USER_W-1:0]     i_m_axis_tuser,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import fbs_pkg::*;

    localparam int TOP_DEPTH  = 2 * ENTRIES_PER_BLOCK - 1;
    localparam int BACK_DEPTH = BACKING_BLOCKS * ENTRIES_PER_BLOCK;

    typedef struct packed {
        logic [ID_W-1:0]    got_id;
        logic               empty_res;
        logic               full_res;
        logic [TOTAL_W-1:0] total_free;
        t_moved             moved;
        logic [MBLK_W-1:0]  moved_block;
    } answer_t;

    logic [ID_W-1:0] top_ids  [TOP_DEPTH];
    logic [ID_W-1:0] back_ids [BACK_DEPTH];
    int              top_fill   = 0;
    int              blocks_out = 0;
    int              held_ids   = 0;
    int              mismatch_count = 0;
    answer_t         pending_answers [$];

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        $display("[%0t] free list result error on %s: expected 0x%0h, observed 0x%0h",
                 $realtime, what, want, got);
        mismatch_count++;
    endtask

    // free list behavior: push, spill top first, refill in stored order, pop
    task automatic apply_request(input logic act, input logic [ID_W-1:0] id,
                                 output answer_t ans);
        int base;
        ans = '0;
        if (act == ACT_FREE) begin
            if (top_fill + 1 < TOP_DEPTH) begin
                top_ids[top_fill] = id;
                top_fill++;
                held_ids++;
            end else if (blocks_out >= BACKING_BLOCKS) begin
                ans.full_res = 1'b1;
            end else begin
                top_ids[TOP_DEPTH-1] = id;
                held_ids++;
                base = blocks_out * ENTRIES_PER_BLOCK;
                for (int k = 0; k < ENTRIES_PER_BLOCK; k++)
                    back_ids[base + k] = top_ids[TOP_DEPTH-1-k];
                top_fill        = ENTRIES_PER_BLOCK - 1;
                ans.moved       = MOVED_SPILL;
                ans.moved_block = blocks_out[MBLK_W-1:0];
                blocks_out++;
            end
        end else begin
            if (held_ids == 0 || (top_fill == 0 && blocks_out == 0)) begin
                ans.empty_res = 1'b1;
            end else begin
                if (top_fill == 0) begin
                    blocks_out--;
                    base = blocks_out * ENTRIES_PER_BLOCK;
                    for (int k = 0; k < ENTRIES_PER_BLOCK; k++)
                        top_ids[k] = back_ids[base + k];
                    top_fill        = ENTRIES_PER_BLOCK;
                    ans.moved       = MOVED_REFILL;
                    ans.moved_block = blocks_out[MBLK_W-1:0];
                end
                top_fill--;
                ans.got_id = top_ids[top_fill];
                held_ids--;
            end
        end
        ans.total_free = held_ids[TOTAL_W-1:0];
    endtask

    always @(posedge i_clk) begin
        answer_t want;
        answer_t seen;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                apply_request(i_s_axis_tuser[0], i_s_axis_tdata[ID_W-1:0], want);
                pending_answers.insert(pending_answers.size(), want);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen.got_id      = i_m_axis_tdata[30:0];
                seen.total_free  = i_m_axis_tdata[41:31];
                seen.moved_block = i_m_axis_tdata[47:42];
                seen.empty_res   = i_m_axis_tuser[0];
                seen.full_res    = i_m_axis_tuser[1];
                seen.moved       = i_m_axis_tuser[3:2];
                if (pending_answers.size() == 0) begin
                    report_mismatch("unrequested result got_id", 0, seen.got_id);
                end else begin
                    want = pending_answers.pop_front();
                    if (seen.got_id !== want.got_id)
                        report_mismatch("got_id", want.got_id, seen.got_id);
                    if (seen.empty_res !== want.empty_res)
                        report_mismatch("empty_res", want.empty_res, seen.empty_res);
                    if (seen.full_res !== want.full_res)
                        report_mismatch("full_res", want.full_res, seen.full_res);
                    if (seen.total_free !== want.total_free)
                        report_mismatch("total_free", want.total_free, seen.total_free);
                    if (seen.moved !== want.moved)
                        report_mismatch("moved", want.moved, seen.moved);
                    if (seen.moved_block !== want.moved_block)
                        report_mismatch("moved_block", want.moved_block, seen.moved_block);
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= pending_answers.size();
    end

endmodule

### dv/tb_top.sv
// testbench top for the free block stack: clock, reset, request and result traffic, verdict
`timescale 1ns / 1ps

module tb_top;
    import fbs_pkg::*;

    localparam int ENTRIES_PER_BLOCK = 16;
    localparam int BACKING_BLOCKS    = 64;
    localparam int CYCLE_LIMIT       = 1_500_000;
    localparam int LONG_HOLD         = 400;
    localparam int DRAIN_CYCLES      = 3 * ENTRIES_PER_BLOCK + 8;
    localparam logic [ID_W-1:0] ID_MAX = '1;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // block_id[30:0], zero pad [31]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // action[0]
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // got_id[30:0], total_free[41:31], moved_block[47:42]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // empty_res[0], full_res[1], moved[3:2]
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int   fail_count;
    int   answers_due;
    int   cycle_count   = 0;
    logic steady_phase  = 1'b0;
    logic hold_receiver = 1'b0;

    always #1 i_clk = ~i_clk;

    free_block_stack_with_spill_core #(
        .ENTRIES_PER_BLOCK(ENTRIES_PER_BLOCK),
        .BACKING_BLOCKS   (BACKING_BLOCKS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    free_block_stack_checker #(
        .ENTRIES_PER_BLOCK(ENTRIES_PER_BLOCK),
        .BACKING_BLOCKS   (BACKING_BLOCKS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_axis_tvalid),
        .i_s_axis_tready(s_axis_tready),
        .i_s_axis_tdata (s_axis_tdata),
        .i_s_axis_tuser (s_axis_tuser),
        .i_m_axis_tvalid(m_axis_tvalid),
        .i_m_axis_tready(m_axis_tready),
        .i_m_axis_tdata (m_axis_tdata),
        .i_m_axis_tuser (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (answers_due)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        logic [31:0] r32;
        int          sel;
        r32 = $urandom;
        sel = $urandom_range(0, 15);
        if (sel == 0) return '0;
        if (sel == 1) return ID_MAX;
        return r32[ID_W-1:0];
    endfunction

    // valid stays high across back-to-back requests
    task automatic send_request(input logic act, input logic [ID_W-1:0] id);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, id};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic run_mix(input int count, input int free_pct);
        logic act;
        repeat (count) begin
            act = ($urandom_range(0, 99) < free_pct) ? ACT_FREE : ACT_ALLOC;
            send_request(act, pick_id());
        end
    endtask

    // result side: ready bursts and gaps, plus one long hold-off on request
    initial begin
        int n;
        int g;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_receiver) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
            m_axis_tready <= 1'b1;
            n = steady_phase ? 50 : $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    initial begin
        int seg_len  [6] = '{80, 150, 300, 100, 350, 100};
        int seg_free [6] = '{75, 50, 97, 50, 1, 45};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty after reset, extreme ids, ordering, back to empty
        send_request(ACT_ALLOC, ID_MAX);
        send_request(ACT_FREE, '0);
        send_request(ACT_FREE, ID_MAX);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, ID_MAX);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, 31'h5555_5555);
        send_request(ACT_FREE, 31'h2aaa_aaaa);
        send_request(ACT_FREE, 31'h0000_0001);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);

        // build up, churn across spill and refill, drain to empty
        for (int s = 0; s < 6; s++) begin
            steady_phase = (s == 3) || ($urandom_range(0, 3) == 0);
            if (s == 1 || s == 2)
                hold_receiver = 1'b1;
            run_mix(seg_len[s], seg_free[s]);
        end
        steady_phase = 1'b0;
        s_axis_tvalid <= 1'b0;

        // pending count is registered in the checker, so it trails the last request
        repeat (2) @(posedge i_clk);
        while (answers_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && answers_due == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/fbs_pkg.sv
design/fbs_front.sv
design/fbs_queue.sv
design/fbs_back.sv
design/free_block_stack_with_spill_core.sv
dv/free_block_stack_checker.sv
dv/tb_top.sv
